[src/lvla_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the location variability loss adjuster.
package lvla_pkg;

    localparam int LOG_W   = 28;
    localparam int LOG_LAT = 25;
    localparam int SQ_IN_W = 29;
    localparam int T_W     = 27;
    localparam int SQ_LAT  = T_W;
    localparam int NUM_W   = 27;
    localparam int DEN_W   = 28;
    localparam int QUO_W   = 27;
    localparam int DIV_LAT = QUO_W;

    localparam logic [7:0] ENV_URBAN_A = 8'd23;
    localparam logic [7:0] ENV_URBAN_B = 8'd24;

    localparam logic [31:0] ONE_Q24  = 32'h0100_0000;
    localparam logic [31:0] HALF_Q24 = 32'h0080_0000;
    localparam logic [31:0] TWO_Q24  = 32'h0200_0000;

    localparam logic [31:0] K_ALPHA =
        32'(((64'd40976291 << 24) + 64'd5000000) / 64'd10000000);
    localparam logic [31:0] K_BETA =
        32'(((64'd12255656 << 24) + 64'd5000000) / 64'd10000000);
    localparam logic [31:0] K_GAMMA =
        32'(((64'd68350345 << 24) + 64'd50000000) / 64'd100000000);
    localparam logic [31:0] K_C0 =
        32'(((64'd2515516698 << 24) + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] K_C1 = 32'(((64'd802853 << 24) + 64'd500000) / 64'd1000000);
    localparam logic [31:0] K_C2 = 32'(((64'd10328 << 24) + 64'd500000) / 64'd1000000);
    localparam logic [31:0] K_D1 = 32'(((64'd1432788 << 24) + 64'd500000) / 64'd1000000);
    localparam logic [31:0] K_D2 = 32'(((64'd189269 << 24) + 64'd500000) / 64'd1000000);
    localparam logic [31:0] K_D3 = 32'(((64'd1308 << 24) + 64'd500000) / 64'd1000000);
    localparam logic [31:0] K_LG2_Q30 =
        32'(((64'd3010299957 << 30) + 64'd5000000000) / 64'd10000000000);
    localparam logic [31:0] K_2LN2 =
        32'(((64'd13862943611 << 24) + 64'd5000000000) / 64'd10000000000);
    localparam logic [31:0] K_NLG_MIN =
        32'(((64'd19931568569 << 24) + 64'd500000000) / 64'd1000000000);

    typedef struct packed {
        logic signed [18:0] adj;
        logic               sat;
    } t_res;

endpackage

[src/lvla_log2.sv]
`timescale 1ns / 1ps
// Pipelined base-2 logarithm of a 16-bit integer in Q24, one fraction bit per stage.
module lvla_log2 import lvla_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [15:0]      i_n,
    output logic [LOG_W-1:0] o_log
);
    localparam int FB = 24;

    logic [30:0]      r_m [0:FB-1];
    logic [LOG_W-1:0] r_r [0:FB];
    logic [3:0]       e;
    logic [15:0]      nsh;

    always_comb begin
        e = '0;
        for (int i = 1; i < 16; i++) begin
            if (i_n[i]) begin
                e = 4'(i);
            end
        end
        nsh = i_n << (4'd15 - e);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= {nsh, 15'd0};
            r_r[0] <= {e, 24'd0};
        end
    end

    for (genvar g = 1; g <= FB; g++) begin : g_sq
        logic [61:0] sq;
        logic [31:0] s;
        assign sq = 62'(r_m[g-1]) * 62'(r_m[g-1]);
        assign s  = sq[61:30];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[g] <= r_r[g-1] | (s[31] ? (LOG_W'(1) << (FB - g)) : '0);
            end
        end
        if (g < FB) begin : g_m
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_m[g] <= s[31] ? s[31:1] : s[30:0];
                end
            end
        end
    end

    assign o_log = r_r[FB];

endmodule

[src/lvla_sqrt.sv]
`timescale 1ns / 1ps
// Pipelined integer square root of a Q24 value, one result bit per stage.
module lvla_sqrt import lvla_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [SQ_IN_W-1:0] i_u,
    output logic [T_W-1:0]     o_t
);
    localparam int VW = 2 * T_W;
    localparam int RW = T_W + 4;

    logic [VW-1:0]  r_v    [1:T_W-1];
    logic [RW-1:0]  r_rem  [1:T_W-1];
    logic [T_W-1:0] r_root [1:T_W];

    for (genvar g = 0; g < T_W; g++) begin : g_st
        logic [VW-1:0]  v;
        logic [RW-1:0]  rem;
        logic [RW-1:0]  rsh;
        logic [RW-1:0]  trial;
        logic [T_W-1:0] root;
        logic           ge;
        if (g == 0) begin : g_in
            assign v    = VW'({i_u, 24'd0});
            assign rem  = '0;
            assign root = '0;
        end else begin : g_mid
            assign v    = r_v[g];
            assign rem  = r_rem[g];
            assign root = r_root[g];
        end
        assign rsh   = {rem[RW-3:0], v[VW-1 -: 2]};
        assign trial = RW'({root, 2'b01});
        assign ge    = (rsh >= trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[g+1] <= {root[T_W-2:0], ge};
            end
        end
        if (g < T_W - 1) begin : g_fw
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v[g+1]   <= v << 2;
                    r_rem[g+1] <= ge ? rsh - trial : rsh;
                end
            end
        end
    end

    assign o_t = r_root[T_W];

endmodule

[src/lvla_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider for the Q24 rational term, one quotient bit per stage.
module lvla_div import lvla_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);
    localparam int RW = NUM_W + 24;
    localparam int CW = DEN_W + QUO_W;

    logic [RW-1:0]    r_rem [1:QUO_W-1];
    logic [DEN_W-1:0] r_den [1:QUO_W-1];
    logic [QUO_W-1:0] r_q   [1:QUO_W];

    for (genvar g = 0; g < QUO_W; g++) begin : g_st
        logic [RW-1:0]    rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] q;
        logic [CW-1:0]    sub;
        logic             ge;
        if (g == 0) begin : g_in
            assign rem = {i_num, 24'd0};
            assign den = i_den;
            assign q   = '0;
        end else begin : g_mid
            assign rem = r_rem[g];
            assign den = r_den[g];
            assign q   = r_q[g];
        end
        assign sub = CW'(den) << (QUO_W - 1 - g);
        assign ge  = (CW'(rem) >= sub);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[g+1] <= q | (QUO_W'(ge) << (QUO_W - 1 - g));
            end
        end
        if (g < QUO_W - 1) begin : g_fw
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g+1] <= ge ? RW'(CW'(rem) - sub) : rem;
                    r_den[g+1] <= den;
                end
            end
        end
    end

    assign o_quo = r_q[QUO_W];

endmodule

[src/lvla_dly.sv]
`timescale 1ns / 1ps
// Enabled delay line that carries side data alongside the pipeline.
module lvla_dly #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);
    logic [W-1:0] r_sh [0:D-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
    end

    assign o_d = r_sh[D-1];

endmodule

[src/location_variability_loss_adjust_top.sv]
`timescale 1ns / 1ps
// Top level of the location variability loss adjuster.
// One item is accepted every cycle while o_ready is high, and each gives one result.
// The depth comes from the two logarithm pipelines, the 27-stage square root and the
// 27-stage divider, each resolving one bit per stage. Results wait in a two-entry
// output buffer; the pipeline holds, and o_ready falls, only while that buffer is full
// and the last stage carries a result.
module location_variability_loss_adjust_top import lvla_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [17:0] i_median_loss,
    input  logic [15:0]        i_freq_mhz,
    input  logic [7:0]         i_env_code,
    input  logic [16:0]        i_reliability,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [18:0] o_adjusted_loss,
    output logic               o_saturated
);
    localparam int ST_T = LOG_LAT + 3 + SQ_LAT;
    localparam int ST_Q = ST_T + 4 + DIV_LAT;
    localparam int NST  = ST_Q + 3;
    localparam int LAST = NST - 1;
    localparam logic signed [22:0] RES_MAX = 23'sd262143;
    localparam logic signed [22:0] RES_MIN = -23'sd262144;
    localparam logic [28:0] NL_TOP = 29'd1 << 28;

    logic           adv;
    logic           acc;
    logic           push;
    logic           pop;
    logic [NST-1:0] r_vld;

    logic signed [17:0] n_dq;
    logic [16:0]        n_d;
    logic               n_pz;
    logic [15:0]        n_p;

    logic signed [17:0] r0_med;
    logic [15:0]        r0_f;
    logic [15:0]        r0_p;
    logic               r0_pz;
    logic               r0_urb;
    logic               r0_neg;

    logic [LOG_W-1:0] lg_f;
    logic [LOG_W-1:0] lg_p;
    logic             pz25;
    logic             urb30;
    logic             neg86;
    logic signed [17:0] med88;
    logic signed [31:0] sig87;
    logic [T_W-1:0]   t55;
    logic [T_W-1:0]   t86;
    logic [QUO_W-1:0] quo;

    logic [56:0] r_lp;
    logic [28:0] r_nl;
    logic [26:0] r_l;
    logic [53:0] r_up;
    logic [53:0] r_ll;
    logic [51:0] r_blp;
    logic [SQ_IN_W-1:0] r_u;
    logic [28:0] r_l2;
    logic [26:0] r_bl;
    logic [53:0] r_gp;
    logic [26:0] r_bl30;
    logic [31:0] n_sig;
    logic signed [31:0] r_sig;

    logic [44:0]      r_pn;
    logic [41:0]      r_pd;
    logic [T_W-1:0]   r_t56;
    logic [24:0]      n_a;
    logic [22:0]      n_b;
    logic [51:0]      r_pn2;
    logic [49:0]      r_pd2;
    logic [T_W-1:0]   r_t57;
    logic [25:0]      n_c;
    logic [NUM_W-1:0] r_num;
    logic [52:0]      r_pd3;
    logic [NUM_W-1:0] r_num59;
    logic [DEN_W-1:0] r_den;

    logic signed [28:0] n_zd;
    logic signed [28:0] r_z;
    logic signed [60:0] r_prod;
    logic [60:0]        n_mag;
    logic [20:0]        n_adj;
    logic signed [22:0] n_med;
    logic signed [22:0] n_res;
    t_res               n_pkt;

    t_res       r_buf [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign adv     = (r_cnt != 2'd2) || !r_vld[LAST];
    assign o_ready = adv;
    assign acc     = i_valid && adv;
    assign push    = adv && r_vld[LAST];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], acc};
        end
    end

    always_comb begin
        n_dq = 18'sd32768 - $signed({1'b0, i_reliability});
        n_d  = n_dq[17] ? 17'(-n_dq) : 17'(n_dq);
        n_pz = (n_d >= 17'd32768);
        n_p  = n_pz ? 16'd1 : 16'(17'd32768 - n_d);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_med <= i_median_loss;
            r0_f   <= (i_freq_mhz == 16'd0) ? 16'd1 : i_freq_mhz;
            r0_p   <= n_p;
            r0_pz  <= n_pz;
            r0_urb <= (i_env_code == ENV_URBAN_A) || (i_env_code == ENV_URBAN_B);
            r0_neg <= (i_reliability > 17'd32768);
        end
    end

    lvla_log2 u_lgf (.i_clk(i_clk), .i_en(adv), .i_n(r0_f), .o_log(lg_f));
    lvla_log2 u_lgp (.i_clk(i_clk), .i_en(adv), .i_n(r0_p), .o_log(lg_p));

    lvla_dly #(.W(1), .D(LOG_LAT)) u_dpz (
        .i_clk(i_clk), .i_en(adv), .i_d(r0_pz), .o_d(pz25)
    );
    lvla_dly #(.W(1), .D(LOG_LAT + 5)) u_durb (
        .i_clk(i_clk), .i_en(adv), .i_d(r0_urb), .o_d(urb30)
    );
    lvla_dly #(.W(1), .D(ST_Q)) u_dneg (
        .i_clk(i_clk), .i_en(adv), .i_d(r0_neg), .o_d(neg86)
    );
    lvla_dly #(.W(18), .D(LAST)) u_dmed (
        .i_clk(i_clk), .i_en(adv), .i_d(r0_med), .o_d(med88)
    );

    // sigma path
    always_comb begin
        n_sig = K_ALPHA + 32'((r_gp + 54'(HALF_Q24)) >> 24) - 32'(r_bl30)
              + (urb30 ? 32'd0 : TWO_Q24);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_lp   <= 57'(lg_f) * 57'(K_LG2_Q30);
            r_nl   <= pz25 ? 29'(K_NLG_MIN) : NL_TOP - 29'(lg_p);
            r_l    <= 27'((r_lp + (57'd1 << 29)) >> 30);
            r_up   <= 54'(r_nl) * 54'(K_2LN2);
            r_ll   <= 54'(r_l) * 54'(r_l);
            r_blp  <= 52'(r_l) * 52'(K_BETA);
            r_u    <= SQ_IN_W'((r_up + 54'(HALF_Q24)) >> 24);
            r_l2   <= 29'((r_ll + 54'(HALF_Q24)) >> 24);
            r_bl   <= 27'((r_blp + 52'(HALF_Q24)) >> 24);
            r_gp   <= 54'(r_l2) * 54'(K_GAMMA);
            r_bl30 <= r_bl;
            r_sig  <= n_sig;
        end
    end

    lvla_dly #(.W(32), .D(ST_Q + 1 - (LOG_LAT + 6))) u_dsig (
        .i_clk(i_clk), .i_en(adv), .i_d(r_sig), .o_d(sig87)
    );

    lvla_sqrt u_sqrt (.i_clk(i_clk), .i_en(adv), .i_u(r_u), .o_t(t55));

    lvla_dly #(.W(T_W), .D(ST_Q - ST_T)) u_dt (
        .i_clk(i_clk), .i_en(adv), .i_d(t55), .o_d(t86)
    );

    // rational term, Horner form
    always_comb begin
        n_a = 25'(r_pn >> 24) + 25'(K_C1);
        n_b = 23'(r_pd >> 24) + 23'(K_D2);
        n_c = 26'(r_pd2 >> 24) + 26'(K_D1);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pn    <= 45'(t55) * 45'(K_C2);
            r_pd    <= 42'(t55) * 42'(K_D3);
            r_t56   <= t55;
            r_pn2   <= 52'(n_a) * 52'(r_t56);
            r_pd2   <= 50'(n_b) * 50'(r_t56);
            r_t57   <= r_t56;
            r_num   <= NUM_W'(r_pn2 >> 24) + NUM_W'(K_C0);
            r_pd3   <= 53'(n_c) * 53'(r_t57);
            r_num59 <= r_num;
            r_den   <= DEN_W'(r_pd3 >> 24) + DEN_W'(ONE_Q24);
        end
    end

    lvla_div u_div (
        .i_clk(i_clk), .i_en(adv), .i_num(r_num59), .i_den(r_den), .o_quo(quo)
    );

    assign n_zd = $signed({2'b00, t86}) - $signed({2'b00, quo});

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_z    <= neg86 ? -n_zd : n_zd;
            r_prod <= 61'(r_z) * 61'(sig87);
        end
    end

    // round, apply and clamp
    always_comb begin
        n_mag = r_prod[60] ? 61'(-r_prod) : 61'(r_prod);
        n_adj = 21'((n_mag + (61'd1 << 39)) >> 40);
        n_med = 23'(med88);
        n_res = r_prod[60] ? n_med + $signed({2'b00, n_adj})
                           : n_med - $signed({2'b00, n_adj});
        if (n_res > RES_MAX) begin
            n_pkt.adj = 19'(RES_MAX);
            n_pkt.sat = 1'b1;
        end else if (n_res < RES_MIN) begin
            n_pkt.adj = 19'(RES_MIN);
            n_pkt.sat = 1'b1;
        end else begin
            n_pkt.adj = n_res[18:0];
            n_pkt.sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= n_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= r_wp ^ push;
            r_rp  <= r_rp ^ pop;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    assign o_valid         = (r_cnt != 2'd0);
    assign o_adjusted_loss = r_buf[r_rp].adj;
    assign o_saturated     = r_buf[r_rp].sat;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt != 2'd2))
        else $error("result pushed into a full output buffer");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> (r_vld == $past(r_vld)))
        else $error("pipeline moved while stalled");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_adjusted_loss == 19'h3FFFF || o_adjusted_loss == 19'h40000))
        else $error("saturated result not at a range limit");

endmodule

[sim/tb_location_variability_loss_adjust_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the location variability loss adjuster: directed and random beats.
module tb_location_variability_loss_adjust_top import lvla_pkg::*;;

    typedef struct {
        logic signed [17:0] med;
        logic [15:0]        freq;
        logic [7:0]         env;
        logic [16:0]        rel;
        logic               sat;
    } t_case;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [17:0] i_median_loss = '0;
    logic [15:0]        i_freq_mhz = '0;
    logic [7:0]         i_env_code = '0;
    logic [16:0]        i_reliability = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [18:0] o_adjusted_loss;
    logic               o_saturated;

    t_res   adj_expected[$];
    int     errors = 0;
    int     sent = 0;
    int     received = 0;
    int     stall_cnt = 0;
    bit     quiet = 1'b0;
    bit     held = 1'b0;
    bit     sat_known = 1'b0;
    logic   sat_typed = 1'b0;

    t_case  directed[] = '{
        '{-18'sd131072, 16'd1,     8'd23,  17'd0,      1'b0},
        '{ 18'sd131071, 16'd65535, 8'd0,   17'd65536,  1'b0},
        '{ 18'sd131071, 16'd65535, 8'd255, 17'd0,      1'b0},
        '{-18'sd131072, 16'd65535, 8'd24,  17'd65536,  1'b0},
        '{-18'sd131072, 16'd0,     8'd22,  17'd0,      1'b0},
        '{ 18'sd0,      16'd0,     8'd25,  17'd32768,  1'b0},
        '{ 18'sd0,      16'd900,   8'd23,  17'd32767,  1'b0},
        '{ 18'sd0,      16'd900,   8'd24,  17'd32769,  1'b0},
        '{ 18'sd2560,   16'd1800,  8'd0,   17'd1,      1'b0},
        '{ 18'sd2560,   16'd1800,  8'd0,   17'd65535,  1'b0},
        '{ 18'sd2560,   16'd1800,  8'd0,   17'd65537,  1'b0},
        '{-18'sd1,      16'd2,     8'd255, 17'd131071, 1'b0},
        '{ 18'sd100,    16'd32768, 8'd128, 17'd58982,  1'b0},
        '{ 18'sd100,    16'd32767, 8'd23,  17'd6554,   1'b0},
        '{ 18'sd131071, 16'd65535, 8'd0,   17'd98304,  1'b0}
    };

    location_variability_loss_adjust_top dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [63:0] log2_fixed(input logic [31:0] n);
        int          e;
        logic [63:0] m;
        logic [63:0] r;
        e = 0;
        if (n == 0) n = 1;
        while (e < 16 && (n >> (e + 1)) != 0) e++;
        m = 64'(n) << (30 - e);
        r = 64'(e) << 24;
        for (int i = 23; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_res adjust_loss(input logic signed [17:0] med, input logic [15:0] f,
                                         input logic [7:0] env, input logic [16:0] rel);
        logic [63:0] lg, lg_sq, nl, u, t, num, den, quo, mag, adj;
        longint      sigma, z, prod, res, d, p, q;
        t_res        r;
        lg = (log2_fixed(32'(f)) * 64'(K_LG2_Q30) + (64'd1 << 29)) >> 30;
        lg_sq = (lg * lg + 64'(HALF_Q24)) >> 24;
        sigma = longint'(K_ALPHA) + longint'((64'(K_GAMMA) * lg_sq + 64'(HALF_Q24)) >> 24)
              - longint'((64'(K_BETA) * lg + 64'(HALF_Q24)) >> 24);
        if (!(env == ENV_URBAN_A || env == ENV_URBAN_B)) sigma += longint'(TWO_Q24);
        q = longint'(rel);
        d = 32768 - q;
        if (d < 0) d = -d;
        p = 32768 - d;
        if (p <= 0) nl = 64'(K_NLG_MIN);
        else nl = (64'd16 << 24) - log2_fixed(32'(p));
        u = (64'(K_2LN2) * nl + 64'(HALF_Q24)) >> 24;
        t = int_sqrt(u << 24);
        num = ((64'(K_C2) * t) >> 24) + 64'(K_C1);
        num = ((num * t) >> 24) + 64'(K_C0);
        den = ((64'(K_D3) * t) >> 24) + 64'(K_D2);
        den = ((den * t) >> 24) + 64'(K_D1);
        den = ((den * t) >> 24) + 64'(ONE_Q24);
        quo = (num << 24) / den;
        z = longint'(t) - longint'(quo);
        if (q > 32768) z = -z;
        prod = z * sigma;
        mag = prod < 0 ? 64'(-prod) : 64'(prod);
        adj = (mag + (64'd1 << 39)) >> 40;
        res = prod < 0 ? longint'(med) + longint'(adj) : longint'(med) - longint'(adj);
        r.sat = 1'b0;
        if (res > 262143) begin
            res = 262143;
            r.sat = 1'b1;
        end
        if (res < -262144) begin
            res = -262144;
            r.sat = 1'b1;
        end
        r.adj = 19'(res);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                e = adjust_loss(i_median_loss, i_freq_mhz, i_env_code, i_reliability);
                if (sat_known) e.sat = sat_typed;
                adj_expected.push_back(e);
                sent++;
            end
            if (o_valid && i_ready) begin
                received++;
                if (adj_expected.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    e = adj_expected.pop_front();
                    if (o_adjusted_loss !== e.adj) begin
                        $error("adjusted_loss expected %0d actual %0d", e.adj, o_adjusted_loss);
                        errors++;
                    end
                    if (o_saturated !== e.sat) begin
                        $error("saturated expected %0d actual %0d", e.sat, o_saturated);
                        errors++;
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cnt = 0;
            else stall_cnt++;
            if (stall_cnt >= 5000) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int hold;
        forever begin
            @(negedge i_clk);
            if (!held && sent >= 600) begin
                held = 1'b1;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= quiet || ($urandom_range(99) >= 16);
            end
        end
    end

    task automatic send_beat(input t_case c, input bit known);
        while (!quiet && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_median_loss <= c.med;
        i_freq_mhz    <= c.freq;
        i_env_code    <= c.env;
        i_reliability <= c.rel;
        sat_known     <= known;
        sat_typed     <= c.sat;
        i_valid       <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    initial begin
        t_case c;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed[k]) send_beat(directed[k], 1'b1);
        for (int n = 0; n < 2000; n++) begin
            quiet = (n >= 1000 && n < 1400);
            if (n == 1500) begin
                i_valid <= 1'b0;
                while (adj_expected.size() != 0) @(negedge i_clk);
            end
            c.med  = 18'($urandom);
            c.freq = 16'($urandom);
            c.env  = ($urandom_range(4) == 0) ? ($urandom_range(1) ? ENV_URBAN_A : ENV_URBAN_B)
                                              : 8'($urandom);
            case ($urandom_range(9))
                0:       c.rel = 17'($urandom_range(131071, 65537));
                1:       c.rel = 17'($urandom_range(40)) + ($urandom_range(1) ? 17'd65496 : 17'd0);
                default: c.rel = 17'($urandom_range(65536));
            endcase
            c.sat = 1'b0;
            send_beat(c, 1'b0);
        end
        i_valid <= 1'b0;
        while (adj_expected.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        $display("Run covered %0d beats in, %0d results out: field extremes, tail clamp,", sent,
                 received);
        $display("reliability above one, urban and other codes, long output stall and a drain.");
        if (errors == 0 && adj_expected.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[sim.f]
src/lvla_pkg.sv
src/lvla_log2.sv
src/lvla_sqrt.sv
src/lvla_div.sv
src/lvla_dly.sv
src/location_variability_loss_adjust_top.sv
sim/tb_location_variability_loss_adjust_top.sv
